>>> rtl/core/link_watchdog_speed_limit_ramp_defines.svh
`ifndef LINK_WATCHDOG_SPEED_LIMIT_RAMP_DEFINES_SVH
`define LINK_WATCHDOG_SPEED_LIMIT_RAMP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define LWSR_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lwsr check failed");

// next-cycle implication, checked outside reset
`define LWSR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lwsr check failed");

`endif

>>> rtl/core/lwsr_pkg.sv
package lwsr_pkg;

  localparam int TIME_BITS = 16;

  localparam int NOW_W    = 16;
  localparam int SW_W     = 8;
  localparam int JOY_W    = 2;
  localparam int SPEED_W  = 16;
  localparam int LIMIT_W  = 15;
  localparam int IVAL_W   = 16;
  localparam int THR_W    = 8;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CMP_W    = 32;

  typedef logic [TIME_BITS-1:0] time_t;

  typedef enum logic [1:0] {
    DRV_STOP = 2'd0,
    DRV_FWD  = 2'd1,
    DRV_REV  = 2'd2
  } drive_state_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPEED_LIMIT  = 2'd0,
    CFG_RAMP_IVAL    = 2'd1,
    CFG_LINK_TIMEOUT = 2'd2,
    CFG_CONNECT_THR  = 2'd3
  } cfg_index_t;

  localparam logic [SW_W-1:0]  SW_CENTER  = 8'd0;
  localparam logic [SW_W-1:0]  SW_LEFT    = 8'd1;
  localparam logic [SW_W-1:0]  SW_RIGHT   = 8'd2;

  localparam logic [JOY_W-1:0] STICK_MID  = 2'd0;
  localparam logic [JOY_W-1:0] STICK_DOWN = 2'd1;
  localparam logic [JOY_W-1:0] STICK_UP   = 2'd2;

  localparam logic [LIMIT_W-1:0] SPEED_LIMIT_RST  = 15'd60;
  localparam logic [IVAL_W-1:0]  RAMP_IVAL_RST    = 16'd10;
  localparam logic [IVAL_W-1:0]  LINK_TIMEOUT_RST = 16'd200;
  localparam logic [THR_W-1:0]   CONNECT_THR_RST  = 8'd10;

endpackage

>>> rtl/core/lwsr_in_if.sv
interface lwsr_in_if
  import lwsr_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic [NOW_W-1:0]          now_ms;
  logic                      payload_valid;
  logic [SW_W-1:0]           switch_code;
  logic [JOY_W-1:0]          joy_class;
  logic signed [SPEED_W-1:0] speed_now;

  modport source (output valid, now_ms, payload_valid, switch_code, joy_class, speed_now,
                  input ready);
  modport sink (input valid, now_ms, payload_valid, switch_code, joy_class, speed_now,
                output ready);
endinterface

>>> rtl/core/lwsr_out_if.sv
interface lwsr_out_if
  import lwsr_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic                      link_down;
  logic                      link_up_event;
  logic                      brake_both;
  logic                      brake_right;
  logic                      release_right;
  logic                      speed_write;
  logic signed [SPEED_W-1:0] speed_cmd;
  logic                      limit_mode;
  logic [1:0]                limit_state;

  modport source (output valid, link_down, link_up_event, brake_both, brake_right,
                  release_right, speed_write, speed_cmd, limit_mode, limit_state,
                  input ready);
  modport sink (input valid, link_down, link_up_event, brake_both, brake_right,
                release_right, speed_write, speed_cmd, limit_mode, limit_state,
                output ready);
endinterface

>>> rtl/core/link_watchdog_speed_limit_ramp.sv
// link watchdog and speed-limit ramp for the right motor
// in_ch carries one poll per item (time, payload flag, switch byte, joystick
// class, current right speed); out_ch returns exactly one result item per poll.
// cfg_we/cfg_index/cfg_data write the four registers; write only while idle.
// an accepted item waits in the input register, is evaluated there and
// lands in the output register, whose valid flag drives out_ch.valid.
// throughput is one item per cycle unless out_ch stalls; the watchdog, ramp
// and decode state all update in the cycle an item leaves the input register.
// when out_ch is stalled both registers hold and in_ch.ready drops only once
// the input register is full behind a held result; no item is lost or doubled.
// reset (rst_n low, synchronous) empties both registers, sets the link lost,
// clears counters, mode and limit state and loads the register defaults.
`include "link_watchdog_speed_limit_ramp_defines.svh"

module link_watchdog_speed_limit_ramp
  import lwsr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  lwsr_in_if.sink              in_ch,
  lwsr_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic [LIMIT_W-1:0] speed_limit_r;
  logic [IVAL_W-1:0]  ramp_ival_r;
  logic [IVAL_W-1:0]  link_timeout_r;
  logic [THR_W-1:0]   connect_thr_r;

  logic                      s1_valid_r;
  logic [NOW_W-1:0]          s1_now_r;
  logic                      s1_pv_r;
  logic [SW_W-1:0]           s1_sw_r;
  logic [JOY_W-1:0]          s1_joy_r;
  logic signed [SPEED_W-1:0] s1_speed_r;

  logic         link_lost_r, link_lost_nxt;
  logic [7:0]   good_r, good_nxt;
  time_t        last_pay_r, last_pay_nxt;
  time_t        last_ramp_r, last_ramp_nxt;
  logic         mode_r, mode_nxt;
  drive_state_t drv_r, drv_nxt;
  logic [SW_W-1:0]  held_sw_r, held_sw_nxt;
  logic [JOY_W-1:0] held_joy_r, held_joy_nxt;

  logic                      out_valid_r;
  logic                      o_link_down_r, o_up_r, o_brake_both_r, o_brake_right_r;
  logic                      o_release_r, o_write_r, o_mode_r;
  logic signed [SPEED_W-1:0] o_cmd_r;
  logic [1:0]                o_state_r;

  logic s1_adv, in_acc, s1_fire;

  time_t                     now_t, el_pay, el_ramp;
  logic [7:0]                good_inc;
  logic                      up_c, brake_c, release_c, write_c, ramp_active;
  logic signed [SPEED_W:0]   target, speed_ext;
  logic signed [SPEED_W-1:0] cmd_c;

  assign s1_adv      = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign s1_fire     = s1_valid_r && s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_limit_r  <= SPEED_LIMIT_RST;
      ramp_ival_r    <= RAMP_IVAL_RST;
      link_timeout_r <= LINK_TIMEOUT_RST;
      connect_thr_r  <= CONNECT_THR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_SPEED_LIMIT:  speed_limit_r  <= cfg_data[LIMIT_W-1:0];
        CFG_RAMP_IVAL:    ramp_ival_r    <= cfg_data[IVAL_W-1:0];
        CFG_LINK_TIMEOUT: link_timeout_r <= cfg_data[IVAL_W-1:0];
        CFG_CONNECT_THR:  connect_thr_r  <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_now_r   <= in_ch.now_ms;
      s1_pv_r    <= in_ch.payload_valid;
      s1_sw_r    <= in_ch.switch_code;
      s1_joy_r   <= in_ch.joy_class;
      s1_speed_r <= in_ch.speed_now;
    end
  end

  always_comb begin
    now_t    = TIME_BITS'(s1_now_r);
    el_pay   = now_t - last_pay_r;
    el_ramp  = now_t - last_ramp_r;
    good_inc = good_r + 8'd1;

    link_lost_nxt = link_lost_r;
    good_nxt      = good_r;
    last_pay_nxt  = last_pay_r;
    last_ramp_nxt = last_ramp_r;
    mode_nxt      = mode_r;
    drv_nxt       = drv_r;
    held_sw_nxt   = held_sw_r;
    held_joy_nxt  = held_joy_r;
    up_c          = 1'b0;
    brake_c       = 1'b0;
    release_c     = 1'b0;
    write_c       = 1'b0;
    cmd_c         = '0;

    // watchdog
    if (s1_pv_r) begin
      last_pay_nxt = now_t;
      if (link_lost_r) begin
        good_nxt = good_inc;
        if (good_inc > connect_thr_r) begin
          link_lost_nxt = 1'b0;
          good_nxt      = '0;
          up_c          = 1'b1;
        end
      end
    end else if (!link_lost_r) begin
      if (CMP_W'(el_pay) > CMP_W'(link_timeout_r)) begin
        link_lost_nxt = 1'b1;
        brake_c       = 1'b1;
        last_pay_nxt  = now_t;
      end
    end

    // ramp, on mode and limit state before this item
    ramp_active = 1'b1;
    case (drv_r)
      DRV_STOP: target = '0;
      DRV_FWD:  target = (SPEED_W+1)'(speed_limit_r);
      DRV_REV:  target = -((SPEED_W+1)'(speed_limit_r));
      default: begin
        target      = '0;
        ramp_active = 1'b0;
      end
    endcase
    speed_ext = (SPEED_W+1)'(s1_speed_r);
    if (s1_pv_r && !link_lost_nxt && mode_r && ramp_active && speed_ext != target
        && CMP_W'(el_ramp) > CMP_W'(ramp_ival_r)) begin
      last_ramp_nxt = now_t;
      write_c       = 1'b1;
      cmd_c         = (speed_ext > target) ? s1_speed_r - 16'sd1 : s1_speed_r + 16'sd1;
    end

    // switch and joystick edges
    if (s1_pv_r) begin
      held_sw_nxt  = s1_sw_r;
      held_joy_nxt = s1_joy_r;
      if (held_sw_r == SW_CENTER && s1_sw_r == SW_LEFT) begin
        mode_nxt  = !mode_r;
        release_c = 1'b1;
        drv_nxt   = DRV_STOP;
      end
      if (held_joy_r == STICK_MID && mode_nxt) begin
        if (s1_joy_r == STICK_DOWN) begin
          if (drv_nxt == DRV_STOP) drv_nxt = DRV_REV;
          else if (drv_nxt == DRV_FWD) drv_nxt = DRV_STOP;
        end else if (s1_joy_r == STICK_UP) begin
          if (drv_nxt == DRV_STOP) drv_nxt = DRV_FWD;
          else if (drv_nxt == DRV_REV) drv_nxt = DRV_STOP;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_lost_r <= 1'b1;
      good_r      <= '0;
      last_pay_r  <= '0;
      last_ramp_r <= '0;
      mode_r      <= 1'b0;
      drv_r       <= DRV_STOP;
      held_sw_r   <= '0;
      held_joy_r  <= '0;
    end else if (s1_fire) begin
      link_lost_r <= link_lost_nxt;
      good_r      <= good_nxt;
      last_pay_r  <= last_pay_nxt;
      last_ramp_r <= last_ramp_nxt;
      mode_r      <= mode_nxt;
      drv_r       <= drv_nxt;
      held_sw_r   <= held_sw_nxt;
      held_joy_r  <= held_joy_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      o_link_down_r   <= link_lost_nxt;
      o_up_r          <= up_c;
      o_brake_both_r  <= brake_c;
      o_brake_right_r <= (held_sw_nxt == SW_RIGHT);
      o_release_r     <= release_c;
      o_write_r       <= write_c;
      o_cmd_r         <= cmd_c;
      o_mode_r        <= mode_nxt;
      o_state_r       <= 2'(drv_nxt);
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.link_down     = o_link_down_r;
  assign out_ch.link_up_event = o_up_r;
  assign out_ch.brake_both    = o_brake_both_r;
  assign out_ch.brake_right   = o_brake_right_r;
  assign out_ch.release_right = o_release_r;
  assign out_ch.speed_write   = o_write_r;
  assign out_ch.speed_cmd     = o_cmd_r;
  assign out_ch.limit_mode    = o_mode_r;
  assign out_ch.limit_state   = o_state_r;

  `LWSR_ASSERT_IMPLIES(a_brake_lost, out_valid_r && o_brake_both_r, o_link_down_r)
  `LWSR_ASSERT_IMPLIES(a_write_link_up, out_valid_r && o_write_r, !o_link_down_r && !o_brake_both_r)
  `LWSR_ASSERT_IMPLIES(a_cmd_zero, out_valid_r && !o_write_r, o_cmd_r == '0)
  `LWSR_ASSERT_NEXT(a_up_event_out, s1_fire && up_c, out_valid_r && o_up_r && !link_lost_r)

endmodule
